FILE: rtl/core/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types, constants and the magic-number classifier for the file
// signature classifier.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // Number of format codes, unknown included.
  localparam int unsigned NUM_FORMATS = 30;

  // Header bytes that any signature test looks at.
  localparam int unsigned SIG_BYTES = 12;
  localparam int unsigned SIG_IDX_W = 4;

  // Width of the header length as the classifier sees it.
  localparam int unsigned LEN_IN_W = 5;

  // Width of a format code.
  localparam int unsigned CODE_W = 5;

  // Width of the per-format byte totals.
  localparam int unsigned TOTAL_W = 64;

  // Width of the file size field.
  localparam int unsigned SIZE_W = 48;

  // Format codes in enumeration order.
  typedef enum logic [CODE_W-1:0] {
    FMT_NONE         = 5'd0,
    FMT_7Z           = 5'd1,
    FMT_AAC          = 5'd2,
    FMT_AVI          = 5'd3,
    FMT_AV1_STILL    = 5'd4,
    FMT_BPG          = 5'd5,
    FMT_BZ2          = 5'd6,
    FMT_LOSSLESS_AUD = 5'd7,
    FMT_FLV          = 5'd8,
    FMT_GIF          = 5'd9,
    FMT_GZ           = 5'd10,
    FMT_HEVC_STILL   = 5'd11,
    FMT_JFIF         = 5'd12,
    FMT_JP2          = 5'd13,
    FMT_LZ4          = 5'd14,
    FMT_MKV          = 5'd15,
    FMT_MOV          = 5'd16,
    FMT_MP3          = 5'd17,
    FMT_MP4          = 5'd18,
    FMT_TS           = 5'd19,
    FMT_OGG          = 5'd20,
    FMT_PNG          = 5'd21,
    FMT_RAR          = 5'd22,
    FMT_TIF          = 5'd23,
    FMT_WAV          = 5'd24,
    FMT_WEB_IMG      = 5'd25,
    FMT_WMA          = 5'd26,
    FMT_XZ           = 5'd27,
    FMT_ZIP          = 5'd28,
    FMT_ZSTD         = 5'd29
  } fmt_t;

  // Kept header bytes, byte 0 first in file order.
  typedef logic [SIG_BYTES-1:0][7:0] hdr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // an input beat is accepted
    logic classify;  // latch the format code and empty the header
    logic update;    // bump the tables and load the output register
  } fsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // output register holds a beat that is being stalled
  } fsc_stat_t;

  // Classifies a header by its magic numbers, first match in priority order.
  // Each test is guarded by the number of bytes it reads.
  function automatic fmt_t classify(hdr_t h, logic [LEN_IN_W-1:0] len);
    fmt_t code;
    logic riff;
    logic ftyp;
    riff = ({h[0], h[1], h[2], h[3]} == 32'h52494646);
    ftyp = ({h[4], h[5], h[6], h[7]} == 32'h66747970);
    if (len >= 5'd6 && {h[0], h[1], h[2], h[3], h[4], h[5]} == 48'hFD377A585A00) begin
      code = FMT_XZ;
    end else if (len >= 5'd4 && {h[0], h[1], h[2], h[3]} == 32'h04224D18) begin
      code = FMT_LZ4;
    end else if (len >= 5'd4 && {h[0], h[1], h[2], h[3]} == 32'h28B52FFD) begin
      code = FMT_ZSTD;
    end else if (len >= 5'd3 && {h[0], h[1], h[2]} == 24'h425A68) begin
      code = FMT_BZ2;
    end else if (len >= 5'd2 && {h[0], h[1]} == 16'h1F8B) begin
      code = FMT_GZ;
    end else if (len >= 5'd7 &&
                 {h[0], h[1], h[2], h[3], h[4], h[5]} == 48'h526172211A07 &&
                 (h[6] == 8'h00 || h[6] == 8'h01)) begin
      code = FMT_RAR;
    end else if (len >= 5'd6 &&
                 {h[0], h[1], h[2], h[3], h[4], h[5]} == 48'h377ABCAF271C) begin
      code = FMT_7Z;
    end else if (len >= 5'd4 && {h[0], h[1], h[2], h[3]} == 32'h504B0304) begin
      code = FMT_ZIP;
    end else if (len >= 5'd4 && {h[0], h[1], h[2], h[3]} == 32'h664C6143) begin
      code = FMT_LOSSLESS_AUD;
    end else if (len >= 5'd4 && {h[0], h[1], h[2], h[3]} == 32'h464C5601) begin
      code = FMT_FLV;
    end else if (len >= 5'd4 && {h[0], h[1], h[2], h[3]} == 32'h1A45DFA3) begin
      code = FMT_MKV;
    end else if (len >= 5'd12 && riff && {h[8], h[9], h[10], h[11]} == 32'h57415645) begin
      code = FMT_WAV;
    end else if (len >= 5'd12 && riff && {h[8], h[9], h[10], h[11]} == 32'h41564920) begin
      code = FMT_AVI;
    end else if (len >= 5'd2 && h[0] == 8'hFF && (h[1] == 8'hF1 || h[1] == 8'hF9)) begin
      code = FMT_AAC;
    end else if (len >= 5'd2 && h[0] == 8'hFF && (h[1] & 8'hF0) == 8'hF0) begin
      code = FMT_MP3;
    end else if (len >= 5'd8 && {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]} ==
                 64'h89504E470D0A1A0A) begin
      code = FMT_PNG;
    end else if (len >= 5'd8 && {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]} ==
                 64'h0000000C6A502020) begin
      code = FMT_JP2;
    end else if (len >= 5'd12 && riff && {h[8], h[9], h[10], h[11]} == 32'h57454250) begin
      code = FMT_WEB_IMG;
    end else if (len >= 5'd6 && {h[0], h[1], h[2], h[3]} == 32'h47494638 &&
                 ({h[4], h[5]} == 16'h3761 || {h[4], h[5]} == 16'h3961)) begin
      code = FMT_GIF;
    end else if (len >= 5'd4 && ({h[0], h[1], h[2], h[3]} == 32'h4D4D002A ||
                                 {h[0], h[1], h[2], h[3]} == 32'h49492A00)) begin
      code = FMT_TIF;
    end else if (len >= 5'd12 && ftyp && ({h[8], h[9], h[10], h[11]} == 32'h68656963 ||
                                          {h[8], h[9], h[10], h[11]} == 32'h6D696631)) begin
      code = FMT_HEVC_STILL;
    end else if (len >= 5'd2 && {h[0], h[1]} == 16'hFFD8) begin
      code = FMT_JFIF;
    end else if (len >= 5'd4 && {h[0], h[1], h[2], h[3]} == 32'h3026B275) begin
      code = FMT_WMA;
    end else if (len >= 5'd4 && {h[0], h[1], h[2], h[3]} == 32'h4F676753) begin
      code = FMT_OGG;
    end else if (len >= 5'd12 && ftyp && {h[8], h[9], h[10], h[11]} == 32'h71742020) begin
      code = FMT_MOV;
    end else if (len >= 5'd12 && ftyp && {h[8], h[9], h[10], h[11]} == 32'h61766966) begin
      code = FMT_AV1_STILL;
    end else if (len >= 5'd4 && {h[0], h[1], h[2], h[3]} == 32'h425047FB) begin
      code = FMT_BPG;
    end else if (len >= 5'd8 && ftyp) begin
      code = FMT_MP4;
    end else if (len >= 5'd1 && h[0] == 8'h47) begin
      code = FMT_TS;
    end else begin
      code = FMT_NONE;
    end
    return code;
  endfunction

endpackage

FILE: rtl/core/file_signature_classifier_top.sv
// ----------------------------------------------------------------------------
// file_signature_classifier_top
// Classifies a file header by its magic numbers and keeps per-format file
// counts and byte totals.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one header byte per beat in file order. A beat
//   with last high closes the header; it may carry no byte (byte_valid low)
//   for an empty file, and its file_size is added to the format's byte total.
//   Beats with byte_valid low and last low are dropped. Bytes beyond
//   HEADER_BYTES are ignored.
//   Header bytes are taken one per cycle. After the closing beat the input
//   stalls while the format code from the signature compare tree is
//   registered, and then while the count tables are read and written and the
//   output register is loaded with the result beat.
//   When the receiver stalls, the result holds in the output register and
//   the next header still streams in; the following table update waits until
//   the pending result beat is taken.
//   Reset clears the header length, all file counts and byte totals, and the
//   output valid.
// ----------------------------------------------------------------------------
module file_signature_classifier_top #(
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    header_byte,
  input  logic          byte_valid,
  input  logic          last,
  input  logic [47:0]   file_size,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [4:0]    format_code,
  output logic [31:0]   format_file_total,
  output logic [63:0]   format_byte_total
);

  fsc_pkg::fsc_cmd_t  cmd;
  fsc_pkg::fsc_stat_t stat;

  // Sequencer.
  fsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Header buffer, classifier and tables.
  fsc_dp #(
    .HEADER_BYTES (HEADER_BYTES),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .header_byte       (header_byte),
    .byte_valid        (byte_valid),
    .last              (last),
    .file_size         (file_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .format_code       (format_code),
    .format_file_total (format_file_total),
    .format_byte_total (format_byte_total)
  );

endmodule

FILE: rtl/core/fsc_ctrl.sv
// ----------------------------------------------------------------------------
// fsc_ctrl
// Controller: collects header beats, then steps through classification and
// the table update, holding off input until the result is loaded.
// ----------------------------------------------------------------------------
module fsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                last,
  output logic                in_stall,
  input  fsc_pkg::fsc_stat_t  stat,
  output fsc_pkg::fsc_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_COLLECT  = 3'b001,
    ST_CLASSIFY = 3'b010,
    ST_UPDATE   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Input beats are taken only while collecting a header.
  assign in_stall = (state != ST_COLLECT);
  assign accept   = in_valid && !in_stall;

  // Commands to the datapath.
  assign cmd.take     = accept;
  assign cmd.classify = (state == ST_CLASSIFY);
  assign cmd.update   = (state == ST_UPDATE) && !stat.out_busy;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (accept && last) begin
          state_next = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!stat.out_busy) begin
          state_next = ST_COLLECT;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/fsc_dp.sv
// ----------------------------------------------------------------------------
// fsc_dp
// Datapath: header buffer, format code register, per-format count and byte
// total tables, and the output register.
// ----------------------------------------------------------------------------
module fsc_dp #(
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fsc_pkg::fsc_cmd_t             cmd,
  output fsc_pkg::fsc_stat_t            stat,
  input  logic [7:0]                    header_byte,
  input  logic                          byte_valid,
  input  logic                          last,
  input  logic [fsc_pkg::SIZE_W-1:0]    file_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fsc_pkg::CODE_W-1:0]    format_code,
  output logic [31:0]                   format_file_total,
  output logic [fsc_pkg::TOTAL_W-1:0]   format_byte_total
);

  localparam int unsigned LEN_W = $clog2(HEADER_BYTES + 1);

  fsc_pkg::hdr_t                  hdr;
  logic [LEN_W-1:0]               len;
  logic [fsc_pkg::SIZE_W-1:0]     size;
  fsc_pkg::fmt_t                  code;
  logic [COUNT_WIDTH-1:0]         cnt_tbl [fsc_pkg::NUM_FORMATS];
  logic [fsc_pkg::TOTAL_W-1:0]    tot_tbl [fsc_pkg::NUM_FORMATS];
  logic [COUNT_WIDTH-1:0]         cnt_new;
  logic [fsc_pkg::TOTAL_W-1:0]    tot_new;
  logic [COUNT_WIDTH+31:0]        cnt_ext;
  logic                           store_en;

  assign stat.out_busy = out_valid && out_stall;

  // A real byte counts while the header has room; only the first bytes are kept.
  assign store_en = cmd.take && byte_valid && (len < LEN_W'(HEADER_BYTES));

  // Header buffer and length.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.classify) begin
      len <= '0;
    end else if (store_en) begin
      len <= len + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (store_en && (len < LEN_W'(fsc_pkg::SIG_BYTES))) begin
      hdr[len[fsc_pkg::SIG_IDX_W-1:0]] <= header_byte;
    end
  end

  // File size of the closing beat, and the format code.
  always_ff @(posedge clk) begin
    if (cmd.take && last) begin
      size <= file_size;
    end
    if (cmd.classify) begin
      code <= fsc_pkg::classify(hdr, fsc_pkg::LEN_IN_W'(len));
    end
  end

  // Updated totals for the latched format; both wrap.
  assign cnt_new = cnt_tbl[code] + COUNT_WIDTH'(1);
  assign tot_new = tot_tbl[code] + fsc_pkg::TOTAL_W'(size);
  assign cnt_ext = {32'b0, cnt_new};

  // Per-format tables, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(fsc_pkg::NUM_FORMATS); i++) begin
        cnt_tbl[i] <= '0;
        tot_tbl[i] <= '0;
      end
    end else if (cmd.update) begin
      cnt_tbl[code] <= cnt_new;
      tot_tbl[code] <= tot_new;
    end
  end

  // Output register: loaded on update, emptied when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      format_code       <= code;
      format_file_total <= cnt_ext[31:0];
      format_byte_total <= tot_new;
    end
  end

endmodule
